>>> rtl/core/sfr_pkg.sv
// sfr_pkg: constants, types and helpers for the status frame receiver.
// No dependencies; imported by the receiver core, its port checker and the bench.
package sfr_pkg;

  localparam logic [7:0] HDR_SYNC    = 8'hff;
  localparam logic [7:0] HDR_MAGIC   = 8'hbe;
  localparam logic [7:0] HDR_VERSION = 8'h01;
  localparam logic [7:0] ID_CONN_REPLY = 8'h21;
  localparam logic [7:0] ID_STATUS     = 8'hf2;
  localparam logic [7:0] CHR_COMMA = 8'h2c;
  localparam logic [7:0] CHR_MINUS = 8'h2d;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_ONE   = 8'h31;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  localparam logic [15:0] MAX_PKT_RESET = 16'd256;
  localparam logic [15:0] MIN_FRAME_LEN = 16'd9;

  // Byte positions within the frame
  localparam logic [15:0] POS_SYNC  = 16'd0;
  localparam logic [15:0] POS_MAGIC = 16'd2;
  localparam logic [15:0] POS_VER   = 16'd3;
  localparam logic [15:0] POS_LEN_H = 16'd4;
  localparam logic [15:0] POS_LEN_L = 16'd5;
  localparam logic [15:0] POS_ID    = 16'd6;
  localparam logic [15:0] POS_BODY  = 16'd7;
  localparam logic [15:0] POS_MAX   = 16'hffff;

  localparam logic [1:0] KIND_OTHER  = 2'd0;
  localparam logic [1:0] KIND_CONN   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] CAL_IDLE    = 2'd0;
  localparam logic [1:0] CAL_RUNNING = 2'd1;
  localparam logic [1:0] CAL_DONE    = 2'd2;

  typedef enum logic [1:0] {
    PH_PAN  = 2'd0,
    PH_TILT = 2'd1,
    PH_DONE = 2'd2
  } parse_phase_e;

  typedef struct packed {
    logic [31:0] acc;   // positive magnitude, mod 2^32
    logic [31:0] nacc;  // running two's complement negation of acc
    logic        neg;
  } num_acc_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHR_ZERO) && (b <= CHR_NINE);
  endfunction

  // One character into a decimal field: '-' restarts negative, digits shift in.
  function automatic num_acc_t feed_value(input num_acc_t cur, input logic [7:0] b);
    num_acc_t    nxt;
    logic [31:0] dig;
    nxt = cur;
    dig = {24'd0, b - CHR_ZERO};
    if (b == CHR_MINUS) begin
      nxt.acc  = '0;
      nxt.nacc = '0;
      nxt.neg  = 1'b1;
    end else if (is_digit(b)) begin
      nxt.acc  = (cur.acc << 3) + (cur.acc << 1) + dig;
      nxt.nacc = (cur.nacc << 3) + (cur.nacc << 1) - dig;
    end
    return nxt;
  endfunction

endpackage

>>> rtl/core/status_frame_receiver_top.sv
// status_frame_receiver_top: byte-stream frame checker and status report parser.
// Depends on sfr_pkg (constants, parse phase enum, decimal accumulator helper).
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | sink      | in_valid_i/in_ready_o  | data_byte_i, end_of_datagram_i
//  out     | source    | out_valid_o/out_ready_i| frame_valid_o .. in_position_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o| cfg_data_i (frame size limit)
//
// One byte per cycle sustained while no end-of-datagram byte waits for the result slot.
// A byte is held in the input register, then the frame stage folds it into the frame
// state (compare, checksum add, times-ten accumulate) and, on the end-of-datagram
// byte, loads the result register as that byte leaves the input register.
// Reset clears all frame state and sets the frame size limit to 256.
// A waiting result holds back only an end-of-datagram byte, which then stalls input.
module status_frame_receiver_top
  import sfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_datagram_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               frame_valid_o,
  output logic [1:0]         message_kind_o,
  output logic               status_parsed_o,
  output logic signed [31:0] pan_position_o,
  output logic signed [31:0] tilt_position_o,
  output logic [1:0]         calibration_state_o,
  output logic               in_position_o,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i
);

  // ---------------- configuration ----------------
  logic [15:0] max_pkt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pkt_q <= MAX_PKT_RESET;
    end else if (cfg_valid_i) begin
      max_pkt_q <= cfg_data_i;
    end
  end

  // ---------------- input register ----------------
  logic       s1_vld_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       out_free;
  logic       s2_go;

  assign out_free   = !out_valid_o || out_ready_i;
  // end-of-datagram bytes need a free result slot, others never wait
  assign s2_go      = s1_vld_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_vld_q || s2_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= end_of_datagram_i;
    end
  end

  // ---------------- frame state ----------------
  logic [15:0]  pos_q, pos_d;
  logic         hdr_ok_q, hdr_ok_d;
  logic [15:0]  len_q, len_d;
  logic [15:0]  sum_q, sum_d;
  logic [15:0]  rsum_q, rsum_d;
  logic [7:0]   id_q, id_d;
  parse_phase_e phase_q, phase_d;
  num_acc_t     pan_q, pan_d;
  num_acc_t     tilt_q, tilt_d;
  logic [15:0]  tcomma_q, tcomma_d;
  logic [7:0]   cal_chr_q, cal_chr_d;
  logic [7:0]   pos_chr_q, pos_chr_d;

  logic [16:0] p_plus1, p_plus2, tc_plus1, tc_plus3, len_plus2, dl_ext;
  logic        in_body;
  logic [7:0]  b;

  assign b         = s1_byte_q;
  assign dl_ext    = {1'b0, len_q};
  assign p_plus1   = {1'b0, pos_q} + 17'd1;
  assign p_plus2   = {1'b0, pos_q} + 17'd2;
  assign tc_plus1  = {1'b0, tcomma_q} + 17'd1;
  assign tc_plus3  = {1'b0, tcomma_q} + 17'd3;
  // bytes 7 .. L-3 carry the ASCII body and are searched for commas
  assign in_body   = (pos_q >= POS_BODY) && (p_plus2 < dl_ext);

  always_comb begin
    pos_d     = pos_q;
    hdr_ok_d  = hdr_ok_q;
    len_d     = len_q;
    sum_d     = sum_q;
    rsum_d    = rsum_q;
    id_d      = id_q;
    phase_d   = phase_q;
    pan_d     = pan_q;
    tilt_d    = tilt_q;
    tcomma_d  = tcomma_q;
    cal_chr_d = cal_chr_q;
    pos_chr_d = pos_chr_q;

    if (pos_q == POS_SYNC  && b != HDR_SYNC)    hdr_ok_d = 1'b0;
    if (pos_q == POS_MAGIC && b != HDR_MAGIC)   hdr_ok_d = 1'b0;
    if (pos_q == POS_VER   && b != HDR_VERSION) hdr_ok_d = 1'b0;
    if (pos_q == POS_LEN_H) len_d = {b, 8'd0};
    if (pos_q == POS_LEN_L) len_d = {len_q[15:8], b};
    if (pos_q == POS_ID)    id_d  = b;

    if (pos_q != POS_SYNC && (pos_q < POS_ID || p_plus2 < dl_ext))
      sum_d = sum_q + {8'd0, b};
    if (pos_q >= POS_ID && p_plus2 == dl_ext) rsum_d = {b, 8'd0};
    if (pos_q >= POS_ID && p_plus1 == dl_ext) rsum_d = rsum_q | {8'd0, b};

    if (in_body) begin
      unique case (phase_q)
        PH_PAN: begin
          if (b == CHR_COMMA) phase_d = PH_TILT;
          else                pan_d   = feed_value(pan_q, b);
        end
        PH_TILT: begin
          if (b == CHR_COMMA) begin
            phase_d  = PH_DONE;
            tcomma_d = pos_q;
          end else begin
            tilt_d = feed_value(tilt_q, b);
          end
        end
        default: ;
      endcase
    end

    // the comma byte itself can never match, so the old phase suffices here
    if (phase_q == PH_DONE && pos_q >= POS_BODY && {1'b0, pos_q} < dl_ext) begin
      if ({1'b0, pos_q} == tc_plus1) cal_chr_d = b;
      if ({1'b0, pos_q} == tc_plus3) pos_chr_d = b;
    end

    if (pos_q != POS_MAX) pos_d = p_plus1[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      hdr_ok_q  <= 1'b1;
      len_q     <= '0;
      sum_q     <= '0;
      rsum_q    <= '0;
      id_q      <= '0;
      phase_q   <= PH_PAN;
      pan_q     <= '0;
      tilt_q    <= '0;
      tcomma_q  <= '0;
      cal_chr_q <= '0;
      pos_chr_q <= '0;
    end else if (s2_go) begin
      if (s1_last_q) begin
        // datagram done: back to the start-of-frame state
        pos_q     <= '0;
        hdr_ok_q  <= 1'b1;
        len_q     <= '0;
        sum_q     <= '0;
        rsum_q    <= '0;
        id_q      <= '0;
        phase_q   <= PH_PAN;
        pan_q     <= '0;
        tilt_q    <= '0;
        tcomma_q  <= '0;
        cal_chr_q <= '0;
        pos_chr_q <= '0;
      end else begin
        pos_q     <= pos_d;
        hdr_ok_q  <= hdr_ok_d;
        len_q     <= len_d;
        sum_q     <= sum_d;
        rsum_q    <= rsum_d;
        id_q      <= id_d;
        phase_q   <= phase_d;
        pan_q     <= pan_d;
        tilt_q    <= tilt_d;
        tcomma_q  <= tcomma_d;
        cal_chr_q <= cal_chr_d;
        pos_chr_q <= pos_chr_d;
      end
    end
  end

  // ---------------- verdict ----------------
  logic        valid_c, parsed_c;
  logic [1:0]  kind_c, cal_c;
  logic [16:0] count_c;

  assign count_c   = p_plus1;
  assign len_plus2 = {1'b0, len_d} + 17'd2;

  always_comb begin
    valid_c = hdr_ok_d && (len_d >= MIN_FRAME_LEN) && (len_plus2 <= {1'b0, max_pkt_q})
              && (count_c >= {1'b0, len_d}) && (sum_d == rsum_d);
    kind_c = KIND_OTHER;
    if (valid_c && id_d == ID_CONN_REPLY) kind_c = KIND_CONN;
    if (valid_c && id_d == ID_STATUS)     kind_c = KIND_STATUS;
    parsed_c = (kind_c == KIND_STATUS) && (phase_d == PH_DONE);
    priority if (cal_chr_d == CHR_ZERO) cal_c = CAL_IDLE;
    else if (cal_chr_d == CHR_ONE)      cal_c = CAL_RUNNING;
    else                                cal_c = CAL_DONE;
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s2_go && s1_last_q) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go && s1_last_q) begin
      frame_valid_o       <= valid_c;
      message_kind_o      <= kind_c;
      status_parsed_o     <= parsed_c;
      pan_position_o      <= !parsed_c ? 32'sd0 :
                             $signed(pan_d.neg ? pan_d.nacc : pan_d.acc);
      tilt_position_o     <= !parsed_c ? 32'sd0 :
                             $signed(tilt_d.neg ? tilt_d.nacc : tilt_d.acc);
      calibration_state_o <= parsed_c ? cal_c : CAL_IDLE;
      in_position_o       <= parsed_c && (pos_chr_d != CHR_ZERO);
    end
  end

endmodule

>>> rtl/core/sfr_port_checker.sv
// sfr_port_checker: port-level assertions for status_frame_receiver_top.
// Depends on sfr_pkg; bound to the top level at the end of this file.
module sfr_port_checker
  import sfr_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               frame_valid_o,
  input logic [1:0]         message_kind_o,
  input logic               status_parsed_o,
  input logic signed [31:0] pan_position_o,
  input logic signed [31:0] tilt_position_o,
  input logic [1:0]         calibration_state_o,
  input logic               in_position_o
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_valid_o)
      && $stable(message_kind_o) && $stable(pan_position_o) && $stable(tilt_position_o))
    else $error("result changed while stalled");

  a_invalid_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_valid_o |-> message_kind_o == KIND_OTHER && !status_parsed_o)
    else $error("invalid frame carries a kind");

  a_parsed_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_parsed_o |-> message_kind_o == KIND_STATUS)
    else $error("parsed flag without status kind");

  a_unparsed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !status_parsed_o |-> pan_position_o == 32'sd0
      && tilt_position_o == 32'sd0 && calibration_state_o == CAL_IDLE && !in_position_o)
    else $error("position fields set without parsed status");

endmodule

bind status_frame_receiver_top sfr_port_checker u_sfr_port_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .frame_valid_o       (frame_valid_o),
  .message_kind_o      (message_kind_o),
  .status_parsed_o     (status_parsed_o),
  .pan_position_o      (pan_position_o),
  .tilt_position_o     (tilt_position_o),
  .calibration_state_o (calibration_state_o),
  .in_position_o       (in_position_o)
);

>>> tb/sfr_verdict_board_pkg.sv
// sfr_verdict_board_pkg: frame verdict predictor and result scoreboard for the receiver bench.
// Depends on sfr_pkg for the header bytes, ASCII codes, kinds and parse phases.
package sfr_verdict_board_pkg;
  import sfr_pkg::*;

  typedef struct packed {
    logic        frame_valid;
    logic [1:0]  kind;
    logic        parsed;
    logic [31:0] pan;
    logic [31:0] tilt;
    logic [1:0]  cal;
    logic        in_pos;
  } frame_verdict_t;

  class frame_verdict_board;
    logic [15:0]    max_pkt;
    logic [15:0]    pos;
    bit             hdr_ok;
    logic [15:0]    decl_len;
    logic [15:0]    sum_run;
    logic [15:0]    sum_rx;
    logic [7:0]     msg_id;
    parse_phase_e   phase;
    logic [31:0]    pan_mag;
    bit             pan_neg;
    logic [31:0]    tilt_mag;
    bit             tilt_neg;
    logic [15:0]    comma2_pos;
    logic [7:0]     cal_chr;
    logic [7:0]     pos_chr;
    frame_verdict_t expected_verdicts[$];
    int unsigned    mismatches;

    function new();
      max_pkt    = MAX_PKT_RESET;
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos        = '0;
      hdr_ok     = 1'b1;
      decl_len   = '0;
      sum_run    = '0;
      sum_rx     = '0;
      msg_id     = '0;
      phase      = PH_PAN;
      pan_mag    = '0;
      pan_neg    = 1'b0;
      tilt_mag   = '0;
      tilt_neg   = 1'b0;
      comma2_pos = '0;
      cal_chr    = '0;
      pos_chr    = '0;
    endfunction

    function void set_max_packet(input logic [15:0] v);
      max_pkt = v;
    endfunction

    function int unsigned pending();
      return expected_verdicts.size();
    endfunction

    // '-' restarts the field as negative, digits shift in decimal, all else skipped
    function void fold_char(input logic [7:0] c, inout logic [31:0] mag, inout bit neg);
      if (c == CHR_MINUS) begin
        mag = '0;
        neg = 1'b1;
      end else if (c >= CHR_ZERO && c <= CHR_NINE) begin
        mag = mag * 32'd10 + 32'(c - CHR_ZERO);
      end
    endfunction

    // One accepted byte; pushes a verdict when it closes the datagram.
    function void take_byte(input logic [7:0] b, input logic eod);
      int unsigned    p;
      int unsigned    dl;
      int unsigned    count;
      bit             valid;
      frame_verdict_t v;
      p  = pos;
      dl = decl_len;

      if (p == POS_SYNC  && b != HDR_SYNC)    hdr_ok = 1'b0;
      if (p == POS_MAGIC && b != HDR_MAGIC)   hdr_ok = 1'b0;
      if (p == POS_VER   && b != HDR_VERSION) hdr_ok = 1'b0;
      if (p == POS_LEN_H) decl_len = {b, 8'h00};
      if (p == POS_LEN_L) decl_len = decl_len | {8'h00, b};
      if (p == POS_ID)    msg_id = b;

      if (p >= 1 && (p < POS_ID || p + 2 < dl)) sum_run = sum_run + {8'h00, b};
      if (p >= POS_ID && p + 2 == dl) sum_rx = {b, 8'h00};
      if (p >= POS_ID && p + 1 == dl) sum_rx = sum_rx | {8'h00, b};

      if (p >= POS_BODY && p + 2 < dl) begin
        case (phase)
          PH_PAN: begin
            if (b == CHR_COMMA) phase = PH_TILT;
            else fold_char(b, pan_mag, pan_neg);
          end
          PH_TILT: begin
            if (b == CHR_COMMA) begin
              phase      = PH_DONE;
              comma2_pos = p[15:0];
            end else begin
              fold_char(b, tilt_mag, tilt_neg);
            end
          end
          default: ;
        endcase
      end
      if (phase == PH_DONE && p >= POS_BODY && p < dl) begin
        if (p == 32'(comma2_pos) + 1) cal_chr = b;
        if (p == 32'(comma2_pos) + 3) pos_chr = b;
      end

      if (pos != POS_MAX) pos = pos + 16'd1;
      if (!eod) return;

      count = p + 1;
      valid = hdr_ok && decl_len >= MIN_FRAME_LEN && 32'(decl_len) + 2 <= 32'(max_pkt)
              && count >= 32'(decl_len) && sum_run == sum_rx;
      v = '0;
      v.frame_valid = valid;
      if (valid && msg_id == ID_CONN_REPLY) v.kind = KIND_CONN;
      if (valid && msg_id == ID_STATUS)     v.kind = KIND_STATUS;
      if (v.kind == KIND_STATUS && phase == PH_DONE) begin
        v.parsed = 1'b1;
        v.pan    = pan_neg ? -pan_mag : pan_mag;
        v.tilt   = tilt_neg ? -tilt_mag : tilt_mag;
        if (cal_chr == CHR_ZERO)     v.cal = CAL_IDLE;
        else if (cal_chr == CHR_ONE) v.cal = CAL_RUNNING;
        else                         v.cal = CAL_DONE;
        v.in_pos = (pos_chr != CHR_ZERO);
      end
      expected_verdicts.push_back(v);
      clear_frame();
    endfunction

    function void compare_field(input string field, input logic signed [31:0] want,
                                input logic signed [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_verdict(input frame_verdict_t got);
      frame_verdict_t want;
      if (expected_verdicts.size() == 0) begin
        $error("result transaction with no datagram outstanding");
        mismatches++;
        return;
      end
      want = expected_verdicts.pop_front();
      compare_field("frame_valid", want.frame_valid, got.frame_valid);
      compare_field("message_kind", want.kind, got.kind);
      compare_field("status_parsed", want.parsed, got.parsed);
      compare_field("pan_position", want.pan, got.pan);
      compare_field("tilt_position", want.tilt, got.tilt);
      compare_field("calibration_state", want.cal, got.cal);
      compare_field("in_position", want.in_pos, got.in_pos);
    endfunction
  endclass

endpackage

>>> tb/status_frame_receiver_top_tb.sv
// status_frame_receiver_top_tb: drives datagrams byte by byte and checks every frame verdict.
// Depends on sfr_pkg, sfr_verdict_board_pkg and the status_frame_receiver_top RTL.
module status_frame_receiver_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;
  import sfr_verdict_board_pkg::*;

  // The limit lies far above the slowest legal run (the widest send gaps, a slow
  // receiver, one long result hold).
  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  // Margin left after the last result is taken, before touching config.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_BYTES = 130;
  localparam int unsigned LONG_DGRAM_BYTES = 200;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN,
    RX_SLOW
  } rx_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         data_byte_i = 8'h00;
  logic               end_of_datagram_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               frame_valid_o;
  logic [1:0]         message_kind_o;
  logic               status_parsed_o;
  logic signed [31:0] pan_position_o;
  logic signed [31:0] tilt_position_o;
  logic [1:0]         calibration_state_o;
  logic               in_position_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [15:0]        cfg_data_i = 16'h0000;

  frame_verdict_board board;

  // sender pacing: bursts of random length separated by gaps up to tx_gap_max
  int unsigned tx_gap_max = 0;
  int unsigned tx_burst_left = 0;
  // receiver pacing
  rx_mode_e    rx_mode = RX_ALWAYS;
  int unsigned rx_hold_left = 0;
  int unsigned rx_tick = 0;
  int unsigned cycle_count = 0;

  // datagram under construction
  logic [7:0] dgram[$];

  status_frame_receiver_top i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("status_frame_receiver_top test failed");
      $finish;
    end
  end

  // Result side: ready is updated at the falling edge. A requested long hold
  // takes priority over the current pattern so the block backs up.
  always @(negedge clk_i) begin
    rx_tick++;
    if (rx_hold_left > 0) begin
      out_ready_i <= 1'b0;
      rx_hold_left--;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  out_ready_i <= 1'b1;
        RX_RANDOM:  out_ready_i <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: out_ready_i <= ((rx_tick % 5) >= 2);
        default:    out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Every result transaction is checked against the oldest outstanding verdict.
  always @(posedge clk_i) begin : result_monitor
    frame_verdict_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.frame_valid = frame_valid_o;
      seen.kind        = message_kind_o;
      seen.parsed      = status_parsed_o;
      seen.pan         = pan_position_o;
      seen.tilt        = tilt_position_o;
      seen.cal         = calibration_state_o;
      seen.in_pos      = in_position_o;
      board.check_verdict(seen);
    end
  end

  // ---------------------------------------------------------------------------
  // Datagram construction
  // ---------------------------------------------------------------------------

  // Header with a random second byte, length left blank until sealing.
  function automatic void start_frame(input logic [7:0] id);
    dgram.delete();
    dgram.push_back(HDR_SYNC);
    dgram.push_back(8'($urandom));
    dgram.push_back(HDR_MAGIC);
    dgram.push_back(HDR_VERSION);
    dgram.push_back(8'h00);
    dgram.push_back(8'h00);
    dgram.push_back(id);
  endfunction

  // Writes length len and the checksum at len-2/len-1, zero-filling up to len.
  // Bytes past len are left in place (they become trailing junk).
  function automatic void seal_frame(input int unsigned len);
    logic [15:0] sum;
    sum = '0;
    dgram[POS_LEN_H] = len[15:8];
    dgram[POS_LEN_L] = len[7:0];
    while (dgram.size() < len) dgram.push_back(8'h00);
    for (int unsigned i = 1; i + 2 < len; i++) sum = sum + {8'h00, dgram[i]};
    dgram[len-2] = sum[15:8];
    dgram[len-1] = sum[7:0];
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) dgram.push_back(s[i]);
  endfunction

  function automatic logic [7:0] junk_char();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CHR_COMMA);
    return c;
  endfunction

  function automatic void put_junk(input int unsigned n);
    repeat (n) dgram.push_back(junk_char());
  endfunction

  // Decimal field: optional sign, mostly short, sometimes long enough to wrap,
  // with the odd stray character mixed in.
  function automatic void put_number();
    int unsigned n;
    if ($urandom_range(0, 2) == 0) dgram.push_back(CHR_MINUS);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6);
    repeat (n) begin
      dgram.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 19) == 0) dgram.push_back(junk_char());
    end
  endfunction

  // Status report "pan,tilt," + cal char, filler, in-position char. The tail is
  // cut at random so the two characters may fall on the checksum or past L.
  function automatic void make_status();
    int unsigned tail;
    start_frame(ID_STATUS);
    if ($urandom_range(0, 19) == 0) put_junk($urandom_range(40, 240));
    put_number();
    if ($urandom_range(0, 9) != 0) dgram.push_back(CHR_COMMA);
    put_number();
    if ($urandom_range(0, 9) != 0) dgram.push_back(CHR_COMMA);
    tail = $urandom_range(0, 5);
    if (tail >= 1) begin
      case ($urandom_range(0, 2))
        0:       dgram.push_back(CHR_ZERO);
        1:       dgram.push_back(CHR_ONE);
        default: dgram.push_back(junk_char());
      endcase
    end
    if (tail >= 2) dgram.push_back(junk_char());
    if (tail >= 3) dgram.push_back($urandom_range(0, 1) ? CHR_ZERO : junk_char());
    if (tail >= 4) put_junk(tail - 3);
    seal_frame(dgram.size() + 2);
  endfunction

  // Mostly well-formed frames with random content; the rest broken or noise.
  function automatic void build_random_dgram();
    int unsigned pick;
    int unsigned idx;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      make_status();
    end else if (pick < 50) begin
      start_frame(ID_CONN_REPLY);
      put_junk($urandom_range(0, 6));
      seal_frame(dgram.size() + 2);
    end else if (pick < 60) begin
      start_frame(8'($urandom));
      put_junk($urandom_range(0, 10));
      seal_frame(dgram.size() + 2);
    end else if (pick < 90) begin
      if ($urandom_range(0, 1)) begin
        make_status();
      end else begin
        start_frame(ID_CONN_REPLY);
        put_junk($urandom_range(0, 4));
        seal_frame(dgram.size() + 2);
      end
      case ($urandom_range(0, 5))
        0: begin  // bad header byte, checksum kept consistent
          case ($urandom_range(0, 2))
            0:       idx = POS_SYNC;
            1:       idx = POS_MAGIC;
            default: idx = POS_VER;
          endcase
          dgram[idx] = dgram[idx] ^ 8'($urandom_range(1, 255));
          seal_frame(dgram.size());
        end
        1: begin  // corrupted byte anywhere after sync
          idx = $urandom_range(1, dgram.size() - 1);
          dgram[idx] = dgram[idx] ^ 8'($urandom_range(1, 255));
        end
        2: repeat ($urandom_range(1, 3)) void'(dgram.pop_back());  // datagram too short
        3: put_junk($urandom_range(1, 5));                          // trailing bytes
        4: begin  // declared length below minimum
          dgram[POS_LEN_H] = 8'h00;
          dgram[POS_LEN_L] = 8'($urandom_range(0, 8));
        end
        default: begin  // declared length above the configured bound
          if (board.max_pkt >= 16'd11 && board.max_pkt <= 16'd400)
            seal_frame(32'(board.max_pkt) - 1 + $urandom_range(0, 2));
          else
            dgram[POS_LEN_H] = 8'hff;
        end
      endcase
    end else begin
      dgram.delete();
      if ($urandom_range(0, 3) == 0) begin
        dgram.push_back(HDR_SYNC);
        dgram.push_back(8'($urandom));
        dgram.push_back(HDR_MAGIC);
      end
      repeat ($urandom_range(1, 24)) dgram.push_back(8'($urandom));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. All tasks start and end just after a falling edge.
  // ---------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b, input logic eod);
    if (tx_gap_max > 0) begin
      if (tx_burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, tx_gap_max)) @(negedge clk_i);
        tx_burst_left = $urandom_range(1, 16);
      end
      tx_burst_left--;
    end
    in_valid_i        <= 1'b1;
    data_byte_i       <= b;
    end_of_datagram_i <= eod;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.take_byte(b, eod);
    @(negedge clk_i);
  endtask

  task automatic send_dgram();
    for (int i = 0; i < dgram.size(); i++) send_byte(dgram[i], i == dgram.size() - 1);
  endtask

  // Stop offering bytes until every outstanding verdict has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_max_packet(input logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_max_packet(v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic pick_pacing();
    case ($urandom_range(0, 2))
      0:       tx_gap_max = 0;
      1:       tx_gap_max = 3;
      default: tx_gap_max = 8;
    endcase
    rx_mode = rx_mode_e'($urandom_range(0, 3));
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [15:0] cfg_plan[6];
    int unsigned sent;
    int unsigned len;

    board = new();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed frames at the reset bound of 256, with light pacing.
    tx_gap_max = 2;
    rx_mode    = RX_RANDOM;

    start_frame(ID_CONN_REPLY);          // minimal connection reply
    seal_frame(dgram.size() + 2);
    send_dgram();
    start_frame(ID_STATUS);              // calibrating, not in position
    put_text("123,-45,1x0");
    seal_frame(dgram.size() + 2);
    send_dgram();
    start_frame(ID_STATUS);              // extremes: pan -2^31, tilt wraps
    put_text("-2147483648,99999999999,0a7");
    seal_frame(dgram.size() + 2);
    send_dgram();
    start_frame(ID_STATUS);              // minus mid-field, stray chars, other cal char
    put_text("12-34,+5 6,zqz");
    seal_frame(dgram.size() + 2);
    send_dgram();
    start_frame(ID_STATUS);              // second comma missing: not parsed
    put_text("77,88");
    seal_frame(dgram.size() + 2);
    send_dgram();
    start_frame(8'h00);                  // unknown message id
    put_text("1,2,3,4");
    seal_frame(dgram.size() + 2);
    send_dgram();
    start_frame(ID_CONN_REPLY);          // bad sync byte
    dgram[POS_SYNC] = 8'h00;
    seal_frame(dgram.size() + 2);
    send_dgram();
    start_frame(ID_CONN_REPLY);          // bad magic
    dgram[POS_MAGIC] = 8'h00;
    seal_frame(dgram.size() + 2);
    send_dgram();
    start_frame(ID_CONN_REPLY);          // bad version
    dgram[POS_VER] = 8'h02;
    seal_frame(dgram.size() + 2);
    send_dgram();
    start_frame(ID_STATUS);              // checksum off by one
    put_text("1,2,1?1");
    seal_frame(dgram.size() + 2);
    dgram[dgram.size()-1] = dgram[dgram.size()-1] ^ 8'h01;
    send_dgram();
    start_frame(ID_CONN_REPLY);          // declared length below minimum
    seal_frame(8);
    send_dgram();
    start_frame(ID_STATUS);              // datagram shorter than declared
    put_text("3,4,1?0");
    seal_frame(dgram.size() + 2);
    void'(dgram.pop_back());
    send_dgram();
    start_frame(ID_CONN_REPLY);          // trailing bytes past L are ignored
    seal_frame(dgram.size() + 2);
    put_junk(4);
    send_dgram();
    start_frame(ID_STATUS);              // cal char on checksum, position char past L
    put_text("5,6,");
    seal_frame(dgram.size() + 2);
    send_dgram();
    start_frame(ID_STATUS);              // position char on last checksum byte
    put_text("5,6,1");
    seal_frame(dgram.size() + 2);
    send_dgram();
    for (len = 254; len <= 255; len++) begin  // at and one past the length bound
      start_frame(ID_STATUS);
      put_text("-9,8,0?0");
      while (dgram.size() < len - 2) dgram.push_back("a");
      seal_frame(len);
      send_dgram();
    end
    dgram.delete();                      // single-byte datagram
    dgram.push_back(8'hff);
    send_dgram();
    dgram.delete();                      // all ones
    repeat (10) dgram.push_back(8'hff);
    send_dgram();

    // A valid frame at the head of a long datagram of random trailing bytes;
    // sent back to back.
    wait_drained();
    tx_gap_max = 0;
    rx_mode    = RX_ALWAYS;
    start_frame(ID_STATUS);
    put_text("42,-42,0?0");
    seal_frame(dgram.size() + 2);
    while (dgram.size() < LONG_DGRAM_BYTES) dgram.push_back(8'($urandom));
    send_dgram();

    // Phases over the register range, including values below the legal range.
    cfg_plan = '{16'd11, 16'd65535, 16'd0, 16'd10, 16'($urandom_range(11, 600)), 16'd256};
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      write_max_packet(cfg_plan[ph]);
      pick_pacing();

      if (cfg_plan[ph] == 16'd11) begin
        start_frame(ID_CONN_REPLY);      // L = 9 just fits
        seal_frame(dgram.size() + 2);
        send_dgram();
        start_frame(ID_CONN_REPLY);      // L = 10 does not
        put_junk(1);
        seal_frame(dgram.size() + 2);
        send_dgram();
      end
      if (cfg_plan[ph] == 16'd65535) begin
        start_frame(ID_STATUS);          // a frame beyond the reset bound
        put_text("-1000,1000,1?0");
        while (dgram.size() < 298) dgram.push_back("b");
        seal_frame(300);
        send_dgram();
        // Results are held back for a long stretch while bytes keep coming,
        // so pending verdicts back up into the input.
        rx_hold_left = 300;
      end

      sent = 0;
      while (sent < PHASE_BYTES) begin
        if ($urandom_range(0, 15) == 0) pick_pacing();
        build_random_dgram();
        send_dgram();
        sent += dgram.size();
      end
    end

    wait_drained();
    if (board.mismatches == 0 && board.pending() == 0)
      $display("status_frame_receiver_top test passed");
    else
      $display("status_frame_receiver_top test failed");
    $finish;
  end

endmodule
